/* rtl/scev_pkg.sv */
// Shared types, fixed-point constants and rounding helper for the sine/cosine evaluator.
// No dependencies; scev_reduce, scev_poly, the top module and the bench import this package.
package scev_pkg;

  // Angle constants in Q.48, rounded to nearest
  localparam longint PI_Q48     = 64'sh3243F6A8885A3;
  localparam longint TWO_PI_Q48 = 64'sh6487ED5110B46;
  localparam longint PI2_Q48    = 64'sh1921FB54442D2;
  localparam longint PI4_Q48    = 64'shC90FDAA22169;
  localparam longint TURNS_BIAS = 64'sd21;
  // Offset that keeps the biased angle non-negative over the whole input range
  localparam longint BIAS_Q48   = PI_Q48 + TURNS_BIAS * TWO_PI_Q48;

  // Width of the biased angle and of the reduced angle
  localparam int REM_W = 57;
  localparam int RED_W = 52;
  // Number of turn-removal stages (biased angle stays below 64 turns)
  localparam int TURN_STAGES = 6;

  // Q2.30 constants, and the half-LSB offset for rounding Q.48 to Q2.30
  localparam longint ONE30  = 64'sd1 << 30;
  localparam longint HALF30 = 64'sd1 << 29;
  localparam longint HALF18 = 64'sd1 << 17;

  // Reciprocal factorials in Q2.30, rounded to nearest
  localparam longint R9 = (ONE30 + 362880 / 2) / 362880;
  localparam longint R8 = (ONE30 + 40320 / 2) / 40320;
  localparam longint R7 = (ONE30 + 5040 / 2) / 5040;
  localparam longint R6 = (ONE30 + 720 / 2) / 720;
  localparam longint R5 = (ONE30 + 120 / 2) / 120;
  localparam longint R4 = (ONE30 + 24 / 2) / 24;
  localparam longint R3 = (ONE30 + 6 / 2) / 6;
  localparam longint R2 = (ONE30 + 2 / 2) / 2;

  // Horner coefficients, highest degree first
  localparam int NCOEF = 5;
  localparam logic signed [32:0] SIN_COEF [NCOEF] =
    '{33'(R9), -33'(R7), 33'(R5), -33'(R3), 33'(ONE30)};
  localparam logic signed [32:0] COS_COEF [NCOEF] =
    '{33'(R8), -33'(R6), 33'(R4), -33'(R2), 33'(ONE30)};

  // Reduced angle handed from the reduction pipe to the polynomial pipe
  typedef struct packed {
    logic               valid;
    logic signed [31:0] t;
    logic               want_cos;
    logic               flip;
  } red_t;

  // Round a Q4.60 product to Q2.30 (round half up)
  function automatic logic signed [32:0] round30(input logic signed [65:0] p);
    logic signed [65:0] q;
    q = (p + 66'(HALF30)) >>> 30;
    return q[32:0];
  endfunction

endpackage

/* rtl/scev_cmd_if.sv */
// Input channel of the sine/cosine evaluator: angle word and operation bit.
// Stand-alone interface; no dependencies.
interface scev_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] angle;
  logic               operation;

  modport source (output valid, output angle, output operation, input ready);
  modport sink   (input valid, input angle, input operation, output ready);
endinterface

/* rtl/scev_res_if.sv */
// Output channel of the sine/cosine evaluator: Q2.30 result word.
// Stand-alone interface; no dependencies.
interface scev_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

/* rtl/scev_reduce.sv */
// Range reduction pipe: removes whole turns, folds into +-pi/2, swaps above pi/4.
// Depends on scev_pkg.
module scev_reduce import scev_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               cmd_valid,
  input  logic signed [31:0] angle,
  input  logic               operation,
  output red_t               red
);

  // Stage map: 0 bias, 1..6 turn removal, 7 center, 8..9 fold, 10 swap, 11 round
  localparam int NSTG = TURN_STAGES + 6;

  logic [NSTG-1:0] vld;
  logic [REM_W-1:0] rem [TURN_STAGES+1];
  logic [TURN_STAGES:0] op;
  logic signed [63:0] biased;

  logic signed [RED_W-1:0] r0, r1, r2, r3;
  logic op0, op1, op2, cos3, cosr;
  logic flip1, flip2, flip3, flipr;
  logic signed [31:0] t;
  logic signed [RED_W-1:0] rsum;

  assign biased = (64'(angle) <<< 24) + BIAS_Q48;
  assign rsum   = r3 + RED_W'(HALF18);

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], cmd_valid};
    end
  end

  // Turn removal: restoring subtraction of 32, 16, ..., 1 turns
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= biased[REM_W-1:0];
      op[0]  <= operation;
      for (int i = 1; i <= TURN_STAGES; i++) begin
        if (rem[i-1] >= (REM_W'(TWO_PI_Q48) << (TURN_STAGES - i))) begin
          rem[i] <= rem[i-1] - (REM_W'(TWO_PI_Q48) << (TURN_STAGES - i));
        end else begin
          rem[i] <= rem[i-1];
        end
        op[i] <= op[i-1];
      end
    end
  end

  // Center, fold, swap and round
  always_ff @(posedge clk) begin
    if (en) begin
      r0  <= $signed({1'b0, rem[TURN_STAGES][RED_W-2:0]}) - RED_W'(PI_Q48);
      op0 <= op[TURN_STAGES];

      if (r0 > RED_W'(PI2_Q48)) begin
        r1    <= r0 - RED_W'(PI_Q48);
        flip1 <= 1'b1;
      end else begin
        r1    <= r0;
        flip1 <= 1'b0;
      end
      op1 <= op0;

      if (r1 < -RED_W'(PI2_Q48)) begin
        r2    <= r1 + RED_W'(PI_Q48);
        flip2 <= ~flip1;
      end else begin
        r2    <= r1;
        flip2 <= flip1;
      end
      op2 <= op1;

      if (r2 > RED_W'(PI4_Q48)) begin
        r3   <= RED_W'(PI2_Q48) - r2;
        cos3 <= ~op2;
      end else begin
        r3   <= r2;
        cos3 <= op2;
      end
      flip3 <= flip2;

      // Round Q.48 to Q2.30
      t     <= 32'(rsum >>> 18);
      cosr  <= cos3;
      flipr <= flip3;
    end
  end

  assign red.valid    = vld[NSTG-1];
  assign red.t        = t;
  assign red.want_cos = cosr;
  assign red.flip     = flipr;

endmodule

/* rtl/scev_poly.sv */
// Polynomial pipe: Horner evaluation of the sine or cosine series on the reduced angle,
// then sign flip and clamp. Depends on scev_pkg.
module scev_poly import scev_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  red_t               red,
  output logic               valid,
  output logic signed [31:0] value
);

  // Stage map: 0 square, 1 round, 2..11 multiply/add pairs, 12 output
  localparam int NSTG  = 13;
  localparam int NCARY = 12;

  typedef struct packed {
    logic signed [31:0] t;
    logic               want_cos;
    logic               flip;
  } carry_t;

  logic [NSTG-1:0] vld;
  carry_t carry [NCARY];
  logic signed [32:0] t2d [2:8];
  logic signed [63:0] t2p;
  logic signed [65:0] prod [NCOEF];
  logic signed [32:0] acc [NCOEF];
  logic signed [32:0] sfin;
  logic signed [33:0] vs;
  logic signed [31:0] vclamp;

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], red.valid};
    end
  end

  // Carry angle, function select and sign along the pipe; square the angle and delay t squared
  always_ff @(posedge clk) begin
    if (en) begin
      carry[0] <= '{t: red.t, want_cos: red.want_cos, flip: red.flip};
      for (int i = 1; i < NCARY; i++) begin
        carry[i] <= carry[i-1];
      end
      t2p    <= red.t * red.t;
      t2d[2] <= round30(66'(t2p));
      for (int i = 3; i <= 8; i++) begin
        t2d[i] <= t2d[i-1];
      end
    end
  end

  // Horner steps: each product registered, then rounded and summed
  always_ff @(posedge clk) begin
    if (en) begin
      prod[0] <= (carry[1].want_cos ? COS_COEF[0] : SIN_COEF[0]) * t2d[2];
      acc[0]  <= round30(prod[0]) + (carry[2].want_cos ? COS_COEF[1] : SIN_COEF[1]);
      prod[1] <= acc[0] * t2d[4];
      acc[1]  <= round30(prod[1]) + (carry[4].want_cos ? COS_COEF[2] : SIN_COEF[2]);
      prod[2] <= acc[1] * t2d[6];
      acc[2]  <= round30(prod[2]) + (carry[6].want_cos ? COS_COEF[3] : SIN_COEF[3]);
      prod[3] <= acc[2] * t2d[8];
      acc[3]  <= round30(prod[3]) + (carry[8].want_cos ? COS_COEF[4] : SIN_COEF[4]);
      // Sine takes one more multiply by t; cosine passes the sum through
      prod[4] <= acc[3] * 33'(carry[9].t);
      sfin    <= acc[3];
      acc[4]  <= carry[10].want_cos ? sfin : round30(prod[4]);
    end
  end

  // Apply the fold sign and clamp to plus or minus one
  always_comb begin
    vs = carry[11].flip ? -34'(acc[4]) : 34'(acc[4]);
    if (vs > 34'(ONE30)) begin
      vclamp = 32'(ONE30);
    end else if (vs < -34'(ONE30)) begin
      vclamp = -32'(ONE30);
    end else begin
      vclamp = vs[31:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      value <= vclamp;
    end
  end

  assign valid = vld[NSTG-1];

endmodule

/* rtl/sine_cosine_evaluator.sv */
// Sine/cosine evaluator: one Q8.24 angle word in, one Q2.30 result word out.
// Depends on scev_pkg, scev_cmd_if, scev_res_if, scev_reduce and scev_poly.
//
// Takes one angle word per clock while the result side is not stalled and returns results
// in order. The pipe holds 12 stages of range reduction (a bias add, six restoring
// turn-subtract stages, centering, two fold stages, the pi/4 swap and rounding to Q2.30)
// and 13 stages of polynomial work (the squaring multiplier, rounding of the square,
// five multiply/add pairs on the shared Horner chain, and the sign/clamp output
// register). A stall on the result side freezes the whole pipe, so input ready
// follows the output register being empty or taken. No state survives between words;
// reset only clears the valid bits.
module sine_cosine_evaluator import scev_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  scev_cmd_if.sink    cmd,
  scev_res_if.source  res
);

  logic en;
  red_t red;

  // Advance the pipe whenever the output register is free or being drained
  assign en        = !res.valid || res.ready;
  assign cmd.ready = en;

  scev_reduce u_reduce (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cmd_valid (cmd.valid),
    .angle     (cmd.angle),
    .operation (cmd.operation),
    .red       (red)
  );

  scev_poly u_poly (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .red   (red),
    .valid (res.valid),
    .value (res.value)
  );

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for sine_cosine_evaluator: drives angle words, checks each Q2.30 result.
// Depends on scev_pkg, scev_cmd_if, scev_res_if and the sine_cosine_evaluator RTL.
module tb_top;
  import scev_pkg::*;

  localparam logic OP_SINE   = 1'b0;
  localparam logic OP_COSINE = 1'b1;

  localparam int  RANDOM_WORDS = 1128;
  localparam int  CALM_WORDS   = 150;
  localparam int  PAUSE_AT     = 400;
  localparam int  DRAIN_CYCLES = 40;
  localparam int  CYCLE_LIMIT  = 200000;
  localparam int  MAX_PRINTS   = 20;

  // Angle constants in Q.48 and Q2.30 helpers for the predictor
  localparam longint A_PI     = 64'sh3243F6A8885A3;
  localparam longint A_TWO_PI = 64'sh6487ED5110B46;
  localparam longint A_HALF   = 64'sh1921FB54442D2;
  localparam longint A_QUART  = 64'shC90FDAA22169;
  localparam longint A_BIAS   = A_PI + 64'sd21 * A_TWO_PI;
  localparam longint Q_ONE    = 64'sd1 <<< 30;
  localparam longint Q_HALF   = 64'sd1 <<< 29;
  localparam longint T_ROUND  = 64'sd1 <<< 17;

  // Reciprocal factorials in Q2.30, rounded to nearest
  localparam longint INV2 = (Q_ONE + 64'sd1) / 64'sd2;
  localparam longint INV3 = (Q_ONE + 64'sd3) / 64'sd6;
  localparam longint INV4 = (Q_ONE + 64'sd12) / 64'sd24;
  localparam longint INV5 = (Q_ONE + 64'sd60) / 64'sd120;
  localparam longint INV6 = (Q_ONE + 64'sd360) / 64'sd720;
  localparam longint INV7 = (Q_ONE + 64'sd2520) / 64'sd5040;
  localparam longint INV8 = (Q_ONE + 64'sd20160) / 64'sd40320;
  localparam longint INV9 = (Q_ONE + 64'sd181440) / 64'sd362880;

  // Handy Q8.24 angles
  localparam logic signed [31:0] ANG_QUART = 32'sh00C90FDB;
  localparam logic signed [31:0] ANG_HALF  = 32'sh01921FB5;
  localparam logic signed [31:0] ANG_PI    = 32'sh03243F6A;
  localparam logic signed [31:0] ANG_4PI   = 32'sh0C90FDAA;

  typedef struct packed {
    logic signed [31:0] angle;
    logic               op;
    logic               typed;
    logic signed [31:0] value;
  } angle_row_t;

  typedef struct packed {
    logic signed [31:0] angle;
    logic               op;
    logic signed [31:0] value;
  } pending_word_t;

  logic clk;
  logic rst;

  scev_cmd_if cmd_bus ();
  scev_res_if res_bus ();

  sine_cosine_evaluator dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .res (res_bus)
  );

  angle_row_t    directed_rows[$];
  pending_word_t pending_results[$];

  int  error_count;
  int  checked_count;
  int  sent_count;
  int  sender_gaps;
  int  result_stalls;
  int  cycle_count;
  bit  calm;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Round a Q4.60 product back to Q2.30
  function automatic longint mul_q30(input longint a, input longint b);
    longint p;
    p = a * b + Q_HALF;
    return p >>> 30;
  endfunction

  // Expected Q2.30 sine or cosine of a Q8.24 angle
  function automatic logic signed [31:0] sincos_of(input logic signed [31:0] angle,
                                                   input logic op);
    longint ang, u, r, t, t2, s, v;
    logic   use_cos;
    logic   negate;
    ang     = angle;
    use_cos = (op == OP_COSINE);
    negate  = 1'b0;
    // reduce to [-pi, pi)
    u = ang * (64'sd1 <<< 24) + A_BIAS;
    r = (u % A_TWO_PI) - A_PI;
    // fold into [-pi/2, pi/2]
    if (r > A_HALF) begin
      r      = r - A_PI;
      negate = 1'b1;
    end
    if (r < -A_HALF) begin
      r      = r + A_PI;
      negate = ~negate;
    end
    // swap to the other function above pi/4
    if (r > A_QUART) begin
      r       = A_HALF - r;
      use_cos = ~use_cos;
    end
    t  = (r + T_ROUND) >>> 18;
    t2 = mul_q30(t, t);
    if (use_cos) begin
      s = INV8;
      s = mul_q30(s, t2) - INV6;
      s = mul_q30(s, t2) + INV4;
      s = mul_q30(s, t2) - INV2;
      v = mul_q30(s, t2) + Q_ONE;
    end else begin
      s = INV9;
      s = mul_q30(s, t2) - INV7;
      s = mul_q30(s, t2) + INV5;
      s = mul_q30(s, t2) - INV3;
      s = mul_q30(s, t2) + Q_ONE;
      v = mul_q30(s, t);
    end
    if (negate) v = -v;
    if (v > Q_ONE) v = Q_ONE;
    if (v < -Q_ONE) v = -Q_ONE;
    return v[31:0];
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic add_row(input logic signed [31:0] angle, input logic op,
                         input logic typed, input logic signed [31:0] value);
    angle_row_t row;
    row.angle = angle;
    row.op    = op;
    row.typed = typed;
    row.value = value;
    directed_rows.push_back(row);
  endtask

  // Present one word and hold it until taken, then log its expected result
  task automatic send_word(input logic signed [31:0] angle, input logic op,
                           input logic typed, input logic signed [31:0] value);
    pending_word_t w;
    cmd_bus.valid     <= 1'b1;
    cmd_bus.angle     <= angle;
    cmd_bus.operation <= op;
    do @(posedge clk); while (!cmd_bus.ready);
    w.angle = angle;
    w.op    = op;
    w.value = typed ? value : sincos_of(angle, op);
    pending_results.push_back(w);
    sent_count++;
  endtask

  // Drop valid for a random burst now and then, unless in the calm stretch
  task automatic maybe_gap();
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 8);
      sender_gaps++;
      cmd_bus.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] random_angle();
    int unsigned pick;
    int          k;
    pick = $urandom_range(0, 9);
    if (pick < 5) return $urandom();
    if (pick < 8) return $signed($urandom_range(0, 2 * ANG_4PI)) - ANG_4PI;
    // near a multiple of pi/4, where folds and swaps switch over
    k = $signed($urandom_range(0, 32)) - 16;
    return k * ANG_QUART + $signed($urandom_range(0, 16)) - 8;
  endfunction

  // Result side: check each taken word, stall in random bursts
  initial begin
    int            hold;
    pending_word_t w;
    hold = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_bus.valid && res_bus.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result word %h", res_bus.value));
        end else begin
          w = pending_results.pop_front();
          checked_count++;
          if (res_bus.value !== w.value)
            report_mismatch($sformatf("angle %h op %0d: value %h, want %h",
                                      w.angle, w.op, res_bus.value, w.value));
        end
      end
      if (!rst && !calm && hold == 0 && $urandom_range(0, 11) == 0) begin
        hold = $urandom_range(1, 8);
        result_stalls++;
      end
      if (hold > 0) begin
        res_bus.ready <= 1'b0;
        hold--;
      end else begin
        res_bus.ready <= !rst;
      end
    end
  end

  // Cycle limit guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    angle_row_t row;
    int         i;
    error_count       = 0;
    checked_count     = 0;
    sent_count        = 0;
    sender_gaps       = 0;
    result_stalls     = 0;
    calm              = 1'b0;
    rst               <= 1'b1;
    cmd_bus.valid     <= 1'b0;
    cmd_bus.angle     <= '0;
    cmd_bus.operation <= OP_SINE;

    // zero angle reads straight off the polynomials
    add_row(32'sh00000000, OP_SINE,   1'b1, 32'sh00000000);
    add_row(32'sh00000000, OP_COSINE, 1'b1, 32'sh40000000);
    // field extremes
    add_row(32'sh7FFFFFFF, OP_SINE,   1'b0, '0);
    add_row(32'sh7FFFFFFF, OP_COSINE, 1'b0, '0);
    add_row(32'sh80000000, OP_SINE,   1'b0, '0);
    add_row(32'sh80000000, OP_COSINE, 1'b0, '0);
    add_row(32'sh00000001, OP_SINE,   1'b0, '0);
    add_row(-32'sd1,       OP_COSINE, 1'b0, '0);
    // around the swap point at pi/4
    add_row(ANG_QUART - 1, OP_SINE,   1'b0, '0);
    add_row(ANG_QUART,     OP_SINE,   1'b0, '0);
    add_row(ANG_QUART,     OP_COSINE, 1'b0, '0);
    // fold edges at plus and minus pi/2 and pi
    add_row(ANG_HALF,      OP_SINE,   1'b0, '0);
    add_row(ANG_HALF,      OP_COSINE, 1'b0, '0);
    add_row(-ANG_HALF,     OP_SINE,   1'b0, '0);
    add_row(ANG_PI,        OP_SINE,   1'b0, '0);
    add_row(ANG_PI,        OP_COSINE, 1'b0, '0);
    add_row(-ANG_PI,       OP_COSINE, 1'b0, '0);
    // negative below -pi/4 after folding: no swap
    add_row(32'shFF000000, OP_SINE,   1'b0, '0);
    add_row(32'shFF000000, OP_COSINE, 1'b0, '0);
    // folded with a sign flip, and a full turn
    add_row(32'sh03000000, OP_SINE,   1'b0, '0);
    add_row(32'sh03000000, OP_COSINE, 1'b0, '0);
    add_row(2 * ANG_PI,    OP_COSINE, 1'b0, '0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words
    foreach (directed_rows[j]) begin
      row = directed_rows[j];
      maybe_gap();
      send_word(row.angle, row.op, row.typed, row.value);
    end

    // random words
    for (i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
      if (i == PAUSE_AT) begin
        // hold off until the pipe has fully drained
        cmd_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        @(posedge clk);
      end else begin
        maybe_gap();
      end
      send_word(random_angle(), $urandom_range(0, 1), 1'b0, '0);
    end
    cmd_bus.valid <= 1'b0;

    // drain and settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d angle words (%0d directed), %0d results compared.",
             sent_count, directed_rows.size(), checked_count);
    $display("Sender gaps: %0d, result stalls: %0d, mismatches: %0d.",
             sender_gaps, result_stalls, error_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
